>>> design/assert_macros.svh
// Assertion helpers shared by the design files.
// Both macros sample on the rising edge of clk and are off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define FBFS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define FBFS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/fbfs_pkg.sv
// ----------------------------------------------------------------------------
// fbfs_pkg
// Types and constants for the free block fit search.
// ----------------------------------------------------------------------------
package fbfs_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = IDX_W + 1;
  localparam int SIZE_W      = 32;
  localparam int EIDX_W      = 8;
  localparam int NCNT_W      = 9;
  localparam int MODE_W      = 3;

  localparam logic [MODE_W-1:0] MODE_EXACT       = 3'd0;
  localparam logic [MODE_W-1:0] MODE_BEST        = 3'd1;
  localparam logic [MODE_W-1:0] MODE_FIRST       = 3'd2;
  localparam logic [MODE_W-1:0] MODE_EXACT_BEST  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_EXACT_FIRST = 3'd4;

  localparam logic ACT_WRITE  = 1'b0;
  localparam logic ACT_SEARCH = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_HOLD
  } fbfs_state_t;

  typedef struct packed {
    logic              wr_en;
    logic [IDX_W-1:0]  wr_idx;
    logic [SIZE_W-1:0] wr_data;
    logic              start;
    logic [SIZE_W-1:0] req;
    logic [CNT_W-1:0]  count;
    logic [MODE_W-1:0] mode;
  } scan_ctl_t;

  typedef struct packed {
    logic              done;
    logic              found;
    logic [EIDX_W-1:0] idx;
    logic [SIZE_W-1:0] size;
  } scan_res_t;

endpackage

>>> design/fbfs_in_if.sv
// ----------------------------------------------------------------------------
// fbfs_in_if
// Input channel: table writes and search requests.
// ----------------------------------------------------------------------------
interface fbfs_in_if import fbfs_pkg::*;;
  logic              valid;
  logic              ready;
  logic              action;
  logic [EIDX_W-1:0] entry_index;
  logic [SIZE_W-1:0] entry_size;
  logic [SIZE_W-1:0] request_size;
  logic [NCNT_W-1:0] entries_in_use;

  modport source (output valid, action, entry_index, entry_size, request_size,
                  entries_in_use, input ready);
  modport sink   (input valid, action, entry_index, entry_size, request_size,
                  entries_in_use, output ready);
endinterface

>>> design/fbfs_out_if.sv
// ----------------------------------------------------------------------------
// fbfs_out_if
// Result channel: one beat per search.
// ----------------------------------------------------------------------------
interface fbfs_out_if import fbfs_pkg::*;;
  logic              valid;
  logic              ready;
  logic              found;
  logic [EIDX_W-1:0] match_index;
  logic [SIZE_W-1:0] match_size;

  modport source (output valid, found, match_index, match_size, input ready);
  modport sink   (input valid, found, match_index, match_size, output ready);
endinterface

>>> design/fbfs_scan.sv
// ----------------------------------------------------------------------------
// fbfs_scan
// Size table memory and the scan engine: one entry read per cycle, exact,
// first fit and best fit tracked in the same pass.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fbfs_scan import fbfs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  scan_ctl_t ctl,
  output scan_res_t res
);

  logic [SIZE_W-1:0] mem [TABLE_DEPTH];

  logic              busy_r;
  logic [CNT_W-1:0]  addr_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [SIZE_W-1:0] req_r;
  logic [MODE_W-1:0] mode_r;
  logic              rd_vld_r;
  logic [IDX_W-1:0]  rd_idx_r;
  logic [SIZE_W-1:0] rd_data_r;

  logic              ex_hit_r;
  logic [IDX_W-1:0]  ex_idx_r;
  logic              ff_hit_r;
  logic [IDX_W-1:0]  ff_idx_r;
  logic [SIZE_W-1:0] ff_size_r;
  logic              bf_hit_r;
  logic [IDX_W-1:0]  bf_idx_r;
  logic [SIZE_W-1:0] bf_size_r;

  logic issue;
  logic done;
  logic is_eq;
  logic is_ge;
  logic is_lt_best;

  assign issue      = busy_r && (addr_r != cnt_r);
  assign done       = busy_r && (addr_r == cnt_r) && !rd_vld_r;
  assign is_eq      = (rd_data_r == req_r);
  assign is_ge      = (rd_data_r >= req_r);
  assign is_lt_best = (rd_data_r < bf_size_r);

  // table port: one write (idle only) and one registered read
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[ctl.wr_idx] <= ctl.wr_data;
    end
    rd_data_r <= mem[addr_r[IDX_W-1:0]];
    rd_idx_r  <= addr_r[IDX_W-1:0];
    if (ctl.start) begin
      req_r  <= ctl.req;
      cnt_r  <= ctl.count;
      mode_r <= ctl.mode;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      addr_r   <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= issue;
      if (ctl.start) begin
        busy_r <= 1'b1;
        addr_r <= '0;
      end else begin
        if (issue) begin
          addr_r <= addr_r + CNT_W'(1);
        end
        if (done) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // trackers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ex_hit_r <= 1'b0;
      ff_hit_r <= 1'b0;
      bf_hit_r <= 1'b0;
    end else if (ctl.start) begin
      ex_hit_r <= 1'b0;
      ff_hit_r <= 1'b0;
      bf_hit_r <= 1'b0;
    end else if (rd_vld_r) begin
      if (is_eq && !ex_hit_r) begin
        ex_hit_r <= 1'b1;
      end
      if (is_ge && !ff_hit_r) begin
        ff_hit_r <= 1'b1;
      end
      if (is_ge) begin
        bf_hit_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_vld_r && !ctl.start) begin
      if (is_eq && !ex_hit_r) begin
        ex_idx_r <= rd_idx_r;
      end
      if (is_ge && !ff_hit_r) begin
        ff_idx_r  <= rd_idx_r;
        ff_size_r <= rd_data_r;
      end
      // strict less keeps the earliest entry on ties
      if (is_ge && (!bf_hit_r || is_lt_best)) begin
        bf_idx_r  <= rd_idx_r;
        bf_size_r <= rd_data_r;
      end
    end
  end

  always_comb begin
    res       = '0;
    res.done  = done;
    unique case (mode_r)
      MODE_EXACT: begin
        if (ex_hit_r) begin
          res.found = 1'b1;
          res.idx   = EIDX_W'(ex_idx_r);
          res.size  = req_r;
        end
      end
      MODE_BEST: begin
        if (bf_hit_r) begin
          res.found = 1'b1;
          res.idx   = EIDX_W'(bf_idx_r);
          res.size  = bf_size_r;
        end
      end
      MODE_FIRST: begin
        if (ff_hit_r) begin
          res.found = 1'b1;
          res.idx   = EIDX_W'(ff_idx_r);
          res.size  = ff_size_r;
        end
      end
      MODE_EXACT_BEST: begin
        if (ex_hit_r) begin
          res.found = 1'b1;
          res.idx   = EIDX_W'(ex_idx_r);
          res.size  = req_r;
        end else if (bf_hit_r) begin
          res.found = 1'b1;
          res.idx   = EIDX_W'(bf_idx_r);
          res.size  = bf_size_r;
        end
      end
      MODE_EXACT_FIRST: begin
        if (ex_hit_r) begin
          res.found = 1'b1;
          res.idx   = EIDX_W'(ex_idx_r);
          res.size  = req_r;
        end else if (ff_hit_r) begin
          res.found = 1'b1;
          res.idx   = EIDX_W'(ff_idx_r);
          res.size  = ff_size_r;
        end
      end
      default: begin
        res.found = 1'b0;
      end
    endcase
  end

  `FBFS_ASSERT_NXT(a_issue_vld, issue && !ctl.start, rd_vld_r, "read issued but no data beat")
  `FBFS_ASSERT_IMP(a_addr_range, busy_r, addr_r <= cnt_r, "scan address ran past count")
  `FBFS_ASSERT_IMP(a_exact_fits, ex_hit_r, ff_hit_r && bf_hit_r, "exact hit without fit hit")

endmodule

>>> design/free_block_fit_search.sv
// Write beat: accepted when idle, stored at the accept edge, no result.
// Search beat: the result beat follows the end of a scan over n entries, where
// n = entries_in_use capped at 256; the one table read port scans one entry per cycle.
// Next beat accepted once the result is in the output register, later if a result waits.
// Reset (rst_n low, synchronous) clears control and fit_mode to 0;
// table contents stay undefined until written.
// ----------------------------------------------------------------------------
// free_block_fit_search
// Free block size table with exact / first fit / best fit search.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module free_block_fit_search import fbfs_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  fbfs_in_if.sink           in_ch,
  fbfs_out_if.source        out_ch,
  input  logic              cfg_we,
  input  logic [MODE_W-1:0] cfg_wdata
);

  fbfs_state_t state_r, state_nxt;
  logic [MODE_W-1:0] fit_mode_r;
  logic              out_valid_r, out_valid_nxt;
  logic              out_found_r;
  logic [EIDX_W-1:0] out_idx_r;
  logic [SIZE_W-1:0] out_size_r;

  scan_ctl_t ctl;
  scan_res_t res;
  logic      in_acc;
  logic      out_free;
  logic      load_out;
  logic      start;

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  always_comb begin
    ctl         = '0;
    ctl.wr_en   = in_acc && (in_ch.action == ACT_WRITE) &&
                  (32'(in_ch.entry_index) < 32'(TABLE_DEPTH));
    ctl.wr_idx  = IDX_W'(in_ch.entry_index);
    ctl.wr_data = in_ch.entry_size;
    ctl.start   = start;
    ctl.req     = in_ch.request_size;
    ctl.count   = (32'(in_ch.entries_in_use) > 32'(TABLE_DEPTH)) ?
                  CNT_W'(TABLE_DEPTH) : CNT_W'(in_ch.entries_in_use);
    ctl.mode    = fit_mode_r;
  end

  fbfs_scan u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fit_mode_r  <= MODE_EXACT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        fit_mode_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_found_r <= res.found;
      out_idx_r   <= res.idx;
      out_size_r  <= res.size;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    in_ch.ready = 1'b0;
    start       = 1'b0;
    load_out    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid && (in_ch.action == ACT_SEARCH)) begin
          start     = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (res.done) begin
          if (out_free) begin
            load_out  = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_HOLD;
          end
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid_nxt      = load_out ? 1'b1 : (out_valid_r && !out_ch.ready);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.found       = out_found_r;
  assign out_ch.match_index = out_idx_r;
  assign out_ch.match_size  = out_size_r;

  `FBFS_ASSERT_NXT(a_search_scan, in_acc && (in_ch.action == ACT_SEARCH), state_r == ST_SCAN, "search beat did not start a scan")
  `FBFS_ASSERT_IMP(a_miss_zero, out_valid_r && !out_found_r, (out_idx_r == '0) && (out_size_r == '0), "miss with nonzero payload")

endmodule

>>> test/tb_free_block_fit_search.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_free_block_fit_search
// Drives table writes and fit searches into free_block_fit_search under every
// fit mode. A predictor keeps its own copy of the size table and of fit_mode
// and works out the found flag, index and size that each search should
// return. The result channel is checked beat by beat against those
// predictions, with idle gaps and back-pressure applied in several phases.
// ----------------------------------------------------------------------------
module tb_free_block_fit_search;
  import fbfs_pkg::*;

  // modes that select no search at all
  localparam logic [MODE_W-1:0] MODE_NONE_LO = 3'd5;
  localparam logic [MODE_W-1:0] MODE_NONE_MID = 3'd6;
  localparam logic [MODE_W-1:0] MODE_NONE_HI = 3'd7;

  localparam int SCAN_SETTLE = 270;        // longest scan plus margin
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int SHOWN_MISMATCHES = 10;
  localparam int POOL_N = 16;

  typedef struct packed {
    logic              found;
    logic [EIDX_W-1:0] idx;
    logic [SIZE_W-1:0] size;
  } fit_result_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_we;
  logic [MODE_W-1:0] cfg_wdata;

  fbfs_in_if  in_ch ();
  fbfs_out_if out_ch ();

  free_block_fit_search dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state
  logic [SIZE_W-1:0] size_copy [TABLE_DEPTH];
  logic [MODE_W-1:0] mode_copy;
  fit_result_t       pending_fits [$];
  logic [SIZE_W-1:0] size_pool [POOL_N];

  int send_idle_pct;
  int recv_stall_pct;
  int mismatches;
  int cycle_count;
  fit_result_t oldest_fit;

  function automatic fit_result_t predict_fit(input logic [SIZE_W-1:0] req,
                                              input logic [NCNT_W-1:0] cnt);
    fit_result_t r;
    int n;
    int i;
    int pick;
    bit hit;
    bit exact_on;
    bit best_on;
    bit first_on;
    r = '0;
    n = (cnt > TABLE_DEPTH) ? TABLE_DEPTH : int'(cnt);
    hit = 1'b0;
    pick = 0;
    exact_on = (mode_copy == MODE_EXACT) || (mode_copy == MODE_EXACT_BEST) ||
               (mode_copy == MODE_EXACT_FIRST);
    best_on  = (mode_copy == MODE_BEST) || (mode_copy == MODE_EXACT_BEST);
    first_on = (mode_copy == MODE_FIRST) || (mode_copy == MODE_EXACT_FIRST);
    if (exact_on) begin
      for (i = 0; i < n && !hit; i++)
        if (size_copy[i] == req) begin
          hit = 1'b1;
          pick = i;
        end
    end
    if (!hit && best_on) begin
      // smallest fitting size, earliest entry on ties
      for (i = 0; i < n; i++)
        if (size_copy[i] >= req && (!hit || size_copy[i] < size_copy[pick])) begin
          hit = 1'b1;
          pick = i;
        end
    end
    if (!hit && first_on) begin
      for (i = 0; i < n && !hit; i++)
        if (size_copy[i] >= req) begin
          hit = 1'b1;
          pick = i;
        end
    end
    if (hit) begin
      r.found = 1'b1;
      r.idx = pick[EIDX_W-1:0];
      r.size = size_copy[pick];
    end
    return r;
  endfunction

  // one input beat; inputs change on the falling edge, ready sampled on the rising
  task automatic send_item(input logic act, input logic [EIDX_W-1:0] idx,
                           input logic [SIZE_W-1:0] esize, input logic [SIZE_W-1:0] req,
                           input logic [NCNT_W-1:0] cnt);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.action = act;
    in_ch.entry_index = idx;
    in_ch.entry_size = esize;
    in_ch.request_size = req;
    in_ch.entries_in_use = cnt;
    in_ch.valid = 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (act == ACT_WRITE)
      size_copy[idx] = esize;
    else
      pending_fits.push_back(predict_fit(req, cnt));
  endtask

  task automatic write_entry(input logic [EIDX_W-1:0] idx, input logic [SIZE_W-1:0] esize);
    send_item(ACT_WRITE, idx, esize, $urandom, NCNT_W'($urandom));
  endtask

  task automatic search(input logic [SIZE_W-1:0] req, input logic [NCNT_W-1:0] cnt);
    send_item(ACT_SEARCH, EIDX_W'($urandom), $urandom, req, cnt);
  endtask

  // wait until every search has answered and the block has gone quiet
  task automatic settle();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pending_fits.size() != 0) @(posedge clk);
    repeat (SCAN_SETTLE) @(posedge clk);
  endtask

  task automatic set_mode(input logic [MODE_W-1:0] m);
    settle();
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = m;
    @(negedge clk);
    cfg_we = 1'b0;
    mode_copy = m;
  endtask

  task automatic refresh_pool();
    int i;
    size_pool[0] = '0;
    size_pool[1] = '1;
    for (i = 2; i < POOL_N; i++)
      size_pool[i] = ($urandom_range(3) == 0) ? $urandom : SIZE_W'($urandom_range(1, 200));
  endtask

  function automatic logic [SIZE_W-1:0] pick_size();
    return ($urandom_range(9) < 8) ? size_pool[$urandom_range(POOL_N - 1)] : $urandom;
  endfunction

  function automatic logic [SIZE_W-1:0] pick_request();
    int r;
    logic [SIZE_W-1:0] v;
    r = $urandom_range(99);
    v = size_pool[$urandom_range(POOL_N - 1)];
    if (r < 50) return v;
    if (r < 60) return v + 1;
    if (r < 70) return v - 1;
    if (r < 85) return $urandom;
    if (r < 92) return '0;
    return '1;
  endfunction

  // mostly short scans, a few longer ones up to the full table and saturating counts
  function automatic logic [NCNT_W-1:0] pick_count();
    int r;
    r = $urandom_range(99);
    if (r < 85) return NCNT_W'($urandom_range(0, 32));
    if (r < 95) return NCNT_W'($urandom_range(33, TABLE_DEPTH));
    return NCNT_W'($urandom_range(TABLE_DEPTH + 1, 511));
  endfunction

  // small hand-built table; only entries 0..7 are scanned here
  task automatic test_directed();
    set_mode(MODE_EXACT);
    write_entry(0, 40);
    write_entry(1, 0);
    write_entry(2, '1);
    write_entry(3, 17);
    write_entry(4, 17);
    write_entry(5, 25);
    write_entry(6, 40);
    write_entry(7, 18);
    write_entry(8'hFF, 32'h8000_0000);
    search(17, 8);
    search(40, 0);                        // empty scan
    search(0, 8);
    set_mode(MODE_BEST);
    search(18, 8);
    search(17, 8);                        // tie between entries 3 and 4
    search('1, 8);
    set_mode(MODE_FIRST);
    search(18, 8);
    search(41, 2);                        // nothing large enough
    set_mode(MODE_EXACT_BEST);
    search(25, 8);
    search(19, 8);
    set_mode(MODE_EXACT_FIRST);
    search(18, 8);
    search(19, 8);
    set_mode(MODE_NONE_LO);
    search(0, 8);
    set_mode(MODE_NONE_HI);
    search(0, 8);
  endtask

  // writes every entry so that any count, saturated or not, is legal
  task automatic test_full_table();
    int i;
    refresh_pool();
    for (i = 0; i < TABLE_DEPTH; i++)
      write_entry(EIDX_W'(i), pick_size());
    set_mode(MODE_BEST);
    search(0, 256);
    search('1, 257);
    search(pick_request(), 511);
    set_mode(MODE_EXACT_FIRST);
    search(size_pool[2], 511);
    search('1, 256);
  endtask

  task automatic test_random_phase(input int idle_pct, input int stall_pct,
                                   input int n_items);
    int i;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    refresh_pool();
    for (i = 0; i < n_items; i++) begin
      if (i % 125 == 0)
        set_mode(MODE_W'($urandom_range(MODE_NONE_HI)));
      if ($urandom_range(99) < 30)
        write_entry(EIDX_W'($urandom), pick_size());
      else
        search(pick_request(), pick_count());
    end
  endtask

  task automatic note_mismatch(input string what, input fit_result_t want,
                               input fit_result_t got);
    mismatches++;
    if (mismatches <= SHOWN_MISMATCHES)
      $display("%0t mismatch (%s): expected found=%0b idx=%0d size=%h, got found=%0b idx=%0d size=%h",
               $realtime, what, want.found, want.idx, want.size,
               got.found, got.idx, got.size);
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_fits.size() == 0) begin
        note_mismatch("no search outstanding", '0,
                      {out_ch.found, out_ch.match_index, out_ch.match_size});
      end else begin
        oldest_fit = pending_fits.pop_front();
        if (out_ch.found !== oldest_fit.found || out_ch.match_index !== oldest_fit.idx ||
            out_ch.match_size !== oldest_fit.size)
          note_mismatch("result beat", oldest_fit,
                        {out_ch.found, out_ch.match_index, out_ch.match_size});
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // receiver back-pressure
  initial begin
    out_ch.ready = 1'b1;
    forever begin
      @(negedge clk);
      out_ch.ready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.action = ACT_WRITE;
    in_ch.entry_index = '0;
    in_ch.entry_size = '0;
    in_ch.request_size = '0;
    in_ch.entries_in_use = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    mismatches = 0;
    cycle_count = 0;
    mode_copy = MODE_EXACT;
    for (int i = 0; i < TABLE_DEPTH; i++) size_copy[i] = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_full_table();
    test_random_phase(0, 0, 500);
    test_random_phase(61, 0, 500);
    test_random_phase(0, 61, 500);
    test_random_phase(18, 18, 500);
    settle();

    if (mismatches == 0 && pending_fits.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
